// ===== rtl/tbs_pkg.sv =====
// Shared types, codes and constants of the token bucket shaper.
`timescale 1ns / 1ps

package tbs_pkg;

   localparam int TBS_TABLE_ENTRIES = 256;

   localparam int DATA_WIDTH   = 32;
   localparam int LEN_WIDTH    = 16;
   localparam int SHIFT_WIDTH  = 4;
   localparam int CMD_WIDTH    = 2;
   localparam int TIDX_WIDTH   = 8;
   localparam int STATUS_WIDTH = 3;
   localparam int CSR_IDX_WIDTH = 2;

   // Request commands
   localparam logic [CMD_WIDTH-1:0] CMD_ENQUEUE = 2'd0;
   localparam logic [CMD_WIDTH-1:0] CMD_DEQUEUE = 2'd1;
   localparam logic [CMD_WIDTH-1:0] CMD_RESET   = 2'd2;
   localparam logic [CMD_WIDTH-1:0] CMD_TABLE   = 2'd3;

   // Response status codes
   localparam logic [STATUS_WIDTH-1:0] ST_DONE      = 3'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_ACCEPTED  = 3'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_DROPPED   = 3'd2;
   localparam logic [STATUS_WIDTH-1:0] ST_SENT      = 3'd3;
   localparam logic [STATUS_WIDTH-1:0] ST_THROTTLED = 3'd4;

   // Configuration register indexes
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SIZE_SHIFT    = 2'd0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BUCKET_DEPTH  = 2'd1;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_BACKLOG_LIMIT = 2'd2;

   localparam logic [SHIFT_WIDTH-1:0] SIZE_SHIFT_RESET = 4'd3;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] backlog;
      logic [DATA_WIDTH-1:0] tokens;
      logic [DATA_WIDTH-1:0] checkpoint;
   } shaper_state_type;

   typedef struct packed {
      logic [DATA_WIDTH-1:0] bucket_depth;
      logic [DATA_WIDTH-1:0] backlog_limit;
   } shaper_cfg_type;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic [DATA_WIDTH-1:0]   wait_time;
      logic [DATA_WIDTH-1:0]   backlog_bytes;
   } shaper_rsp_type;

endpackage

// ===== rtl/tbs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module tbs_ram #(
   parameter int WIDTH      = 32,
   parameter int DEPTH      = 256,
   parameter int ADDR_WIDTH = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [ADDR_WIDTH-1:0] wr_addr,
   input  logic [WIDTH-1:0]      wr_data,
   input  logic                  rd_en,
   input  logic [ADDR_WIDTH-1:0] rd_addr,
   output logic [WIDTH-1:0]      rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tbs_index.sv =====
// Table address generation: size class lookup index and table write decode.
`timescale 1ns / 1ps

module tbs_index #(
   parameter int TABLE_ENTRIES = 256,
   parameter int ADDR_WIDTH    = $clog2(TABLE_ENTRIES)
) (
   input  logic [tbs_pkg::LEN_WIDTH-1:0]   packet_length,
   input  logic [tbs_pkg::SHIFT_WIDTH-1:0] size_shift,
   input  logic [tbs_pkg::TIDX_WIDTH-1:0]  table_index,
   output logic [ADDR_WIDTH-1:0]           rd_addr,
   output logic                            wr_in_range,
   output logic [ADDR_WIDTH-1:0]           wr_addr
);
   import tbs_pkg::*;

   logic [LEN_WIDTH-1:0] size_class;

   // Saturate the size class at the last table entry.
   always_comb begin
      size_class = packet_length >> size_shift;
      if (32'(size_class) > 32'(TABLE_ENTRIES - 1)) begin
         rd_addr = ADDR_WIDTH'(TABLE_ENTRIES - 1);
      end else begin
         rd_addr = ADDR_WIDTH'(size_class);
      end
   end

   assign wr_in_range = 32'(table_index) < 32'(TABLE_ENTRIES);
   assign wr_addr     = ADDR_WIDTH'(table_index);

endmodule

// ===== rtl/tbs_decide.sv =====
// Per-request decision: tail-drop check, token credit, state update and response.
`timescale 1ns / 1ps

module tbs_decide (
   input  logic [tbs_pkg::CMD_WIDTH-1:0]  command,
   input  logic [tbs_pkg::LEN_WIDTH-1:0]  packet_length,
   input  logic [tbs_pkg::DATA_WIDTH-1:0] now_time,
   input  logic [tbs_pkg::DATA_WIDTH-1:0] table_data,
   input  tbs_pkg::shaper_cfg_type        cfg,
   input  tbs_pkg::shaper_state_type      cur,
   output tbs_pkg::shaper_state_type      nxt,
   output tbs_pkg::shaper_rsp_type        rsp
);
   import tbs_pkg::*;

   logic [DATA_WIDTH:0]   enq_sum;
   logic [DATA_WIDTH-1:0] elapsed_raw;
   logic [DATA_WIDTH-1:0] elapsed;
   logic [DATA_WIDTH+1:0] credit;
   logic [DATA_WIDTH+1:0] deficit;

   always_comb begin
      enq_sum     = {1'b0, cur.backlog} + (DATA_WIDTH + 1)'(packet_length);
      elapsed_raw = now_time - cur.checkpoint;
      elapsed     = (elapsed_raw > cfg.bucket_depth) ? cfg.bucket_depth : elapsed_raw;
      credit      = (DATA_WIDTH + 2)'(elapsed) + (DATA_WIDTH + 2)'(cur.tokens)
                  - (DATA_WIDTH + 2)'(table_data);
      deficit     = (DATA_WIDTH + 2)'(0) - credit;

      nxt           = cur;
      rsp.status    = ST_DONE;
      rsp.wait_time = '0;

      case (command)
         CMD_ENQUEUE: begin
            if (enq_sum <= {1'b0, cfg.backlog_limit}) begin
               nxt.backlog = enq_sum[DATA_WIDTH-1:0];
               rsp.status  = ST_ACCEPTED;
            end else begin
               rsp.status  = ST_DROPPED;
            end
         end
         CMD_DEQUEUE: begin
            if (!credit[DATA_WIDTH+1]) begin
               nxt.checkpoint = now_time;
               if (credit[DATA_WIDTH:0] > {1'b0, cfg.bucket_depth}) begin
                  nxt.tokens = cfg.bucket_depth;
               end else begin
                  nxt.tokens = credit[DATA_WIDTH-1:0];
               end
               if (cur.backlog >= DATA_WIDTH'(packet_length)) begin
                  nxt.backlog = cur.backlog - DATA_WIDTH'(packet_length);
               end else begin
                  nxt.backlog = '0;
               end
               rsp.status = ST_SENT;
            end else begin
               rsp.wait_time = deficit[DATA_WIDTH-1:0];
               rsp.status    = ST_THROTTLED;
            end
         end
         CMD_RESET: begin
            nxt.backlog    = '0;
            nxt.checkpoint = now_time;
            nxt.tokens     = cfg.bucket_depth;
         end
         default: begin
            // Table write: the entry is stored at request time.
         end
      endcase

      rsp.backlog_bytes = nxt.backlog;
   end

endmodule

// ===== rtl/token_bucket_shaper.sv =====
// Top level of the token bucket shaper: request pipeline, state and response register.
`timescale 1ns / 1ps

// Token bucket shaper with microsecond time units. Each request carries a
// command: enqueue (tail-drop check of the byte backlog against
// backlog_limit), dequeue attempt (credit = min(now - checkpoint,
// bucket_depth) + tokens - transmit time of the packet's size class; send when
// the credit is non-negative, otherwise report throttled with the deficit),
// reset (empty the backlog, fill the bucket, move the checkpoint to now) or
// table write (load one entry of the size-class transmit-time table). Every
// request yields exactly one response. The size-class table lives in a
// synchronous RAM of TABLE_ENTRIES words; the size class is
// packet_length >> size_shift, saturated at the last entry, and only entries
// that have been written may be looked up. A request goes from acceptance
// to a valid response through the table RAM read and then the credit
// arithmetic and state update. Requests are accepted one per cycle as
// long as responses are taken; a response waiting under rsp_stall still lets
// one more request enter and read the table, after which req_stall rises.
// Configuration registers are written through csr_wr_en / csr_index /
// csr_wr_data and must only change while no request is in flight.
module token_bucket_shaper #(
   parameter int TABLE_ENTRIES = tbs_pkg::TBS_TABLE_ENTRIES
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [tbs_pkg::CMD_WIDTH-1:0]       req_command,
   input  logic [tbs_pkg::LEN_WIDTH-1:0]       req_packet_length,
   input  logic [tbs_pkg::DATA_WIDTH-1:0]      req_now_time,
   input  logic [tbs_pkg::TIDX_WIDTH-1:0]      req_table_index,
   input  logic [tbs_pkg::DATA_WIDTH-1:0]      req_table_value,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [tbs_pkg::STATUS_WIDTH-1:0]    rsp_status,
   output logic [tbs_pkg::DATA_WIDTH-1:0]      rsp_wait_time,
   output logic [tbs_pkg::DATA_WIDTH-1:0]      rsp_backlog_bytes,
   // configuration write port
   input  logic                                csr_wr_en,
   input  logic [tbs_pkg::CSR_IDX_WIDTH-1:0]   csr_index,
   input  logic [tbs_pkg::DATA_WIDTH-1:0]      csr_wr_data
);
   import tbs_pkg::*;

   localparam int ADDR_WIDTH = $clog2(TABLE_ENTRIES);

   // configuration
   logic [SHIFT_WIDTH-1:0] size_shift_ff;
   shaper_cfg_type         cfg_ff;

   // architectural state
   shaper_state_type state_ff;
   shaper_state_type state_in;

   // decision stage (table read data arrives here)
   logic                  s1_valid_ff;
   logic [CMD_WIDTH-1:0]  s1_command_ff;
   logic [LEN_WIDTH-1:0]  s1_length_ff;
   logic [DATA_WIDTH-1:0] s1_now_ff;

   // response register
   logic           rsp_valid_ff;
   shaper_rsp_type rsp_ff;
   shaper_rsp_type rsp_in;

   logic                  req_accept;
   logic                  out_free;
   logic                  s1_advance;
   logic [ADDR_WIDTH-1:0] rd_addr;
   logic [ADDR_WIDTH-1:0] wr_addr;
   logic                  wr_in_range;
   logic                  tbl_wr_en;
   logic [DATA_WIDTH-1:0] tbl_rd_data;

   // The response register frees when empty or being taken; the decision
   // stage advances into it then, and a new request may follow right behind.
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign s1_advance = s1_valid_ff && out_free;
   assign req_stall  = s1_valid_ff && !out_free;
   assign req_accept = req_valid && !req_stall;

   // Table writes land at acceptance, so a lookup accepted in the next cycle
   // already reads the new entry; no forwarding is needed.
   assign tbl_wr_en = req_accept && (req_command == CMD_TABLE) && wr_in_range;

   tbs_index #(
      .TABLE_ENTRIES (TABLE_ENTRIES),
      .ADDR_WIDTH    (ADDR_WIDTH)
   ) u_index (
      .packet_length (req_packet_length),
      .size_shift    (size_shift_ff),
      .table_index   (req_table_index),
      .rd_addr       (rd_addr),
      .wr_in_range   (wr_in_range),
      .wr_addr       (wr_addr)
   );

   // Read only on acceptance so the data holds while the decision stage waits.
   tbs_ram #(
      .WIDTH      (DATA_WIDTH),
      .DEPTH      (TABLE_ENTRIES),
      .ADDR_WIDTH (ADDR_WIDTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (tbl_wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_table_value),
      .rd_en   (req_accept),
      .rd_addr (rd_addr),
      .rd_data (tbl_rd_data)
   );

   // State is touched only by the request in the decision stage, in order,
   // so each request sees everything its predecessors left behind.
   tbs_decide u_decide (
      .command       (s1_command_ff),
      .packet_length (s1_length_ff),
      .now_time      (s1_now_ff),
      .table_data    (tbl_rd_data),
      .cfg           (cfg_ff),
      .cur           (state_ff),
      .nxt           (state_in),
      .rsp           (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         size_shift_ff        <= SIZE_SHIFT_RESET;
         cfg_ff.bucket_depth  <= '0;
         cfg_ff.backlog_limit <= '0;
         state_ff             <= '0;
         s1_valid_ff          <= 1'b0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         // configuration writes; unknown indexes are ignored
         if (csr_wr_en) begin
            case (csr_index)
               CSR_SIZE_SHIFT:    size_shift_ff        <= csr_wr_data[SHIFT_WIDTH-1:0];
               CSR_BUCKET_DEPTH:  cfg_ff.bucket_depth  <= csr_wr_data;
               CSR_BACKLOG_LIMIT: cfg_ff.backlog_limit <= csr_wr_data;
               default: ;
            endcase
         end

         // advance the decision stage: commit state, load response
         if (s1_advance) begin
            state_ff <= state_in;
         end
         if (out_free) begin
            rsp_valid_ff <= s1_valid_ff;
         end
         if (!req_stall) begin
            s1_valid_ff <= req_valid;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_command_ff <= req_command;
         s1_length_ff  <= req_packet_length;
         s1_now_ff     <= req_now_time;
      end
      if (s1_advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_ff.status;
   assign rsp_wait_time     = rsp_ff.wait_time;
   assign rsp_backlog_bytes = rsp_ff.backlog_bytes;

endmodule

// ===== rtl/tbs_checker.sv =====
// Port-level checks of the token bucket shaper and their binding.
`timescale 1ns / 1ps

module tbs_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_valid,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [tbs_pkg::STATUS_WIDTH-1:0]  rsp_status,
   input logic [tbs_pkg::DATA_WIDTH-1:0]    rsp_wait_time,
   input logic [tbs_pkg::DATA_WIDTH-1:0]    rsp_backlog_bytes
);
   import tbs_pkg::*;

   // a request accepted now has a response showing once it has passed the table read and decision stage
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> ##2 rsp_valid)
      else $error("accepted request produced no response");

   // a deficit is reported only with a throttled status
   a_wait_only_throttled: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != ST_THROTTLED)) |-> (rsp_wait_time == '0))
      else $error("nonzero wait time without throttle");

   // only defined status codes are reported
   a_status_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status == ST_DONE || rsp_status == ST_ACCEPTED ||
                     rsp_status == ST_DROPPED || rsp_status == ST_SENT ||
                     rsp_status == ST_THROTTLED))
      else $error("illegal response status");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_status) &&
                                    $stable(rsp_backlog_bytes)))
      else $error("stalled response changed");

endmodule

bind token_bucket_shaper tbs_checker u_tbs_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_valid),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_status        (rsp_status),
   .rsp_wait_time     (rsp_wait_time),
   .rsp_backlog_bytes (rsp_backlog_bytes)
);

// ===== tb/tb.sv =====
// Self-checking testbench for the token bucket shaper: directed table, random phases, predictor.
`timescale 1ns / 1ps

module tb;
   import tbs_pkg::*;

   // Longest quiet stretch is made of sender gap, receiver stall, pipeline and register
   // writes; allow many times that before declaring a hang.
   localparam int IDLE_LIMIT     = 400;
   localparam int RANDOM_PHASES  = 7;
   localparam int PHASE_REQUESTS = 100;
   localparam int TAIL_CYCLES    = 8;

   typedef struct packed {
      logic [CMD_WIDTH-1:0]  command;
      logic [LEN_WIDTH-1:0]  packet_length;
      logic [DATA_WIDTH-1:0] now_time;
      logic [TIDX_WIDTH-1:0] table_index;
      logic [DATA_WIDTH-1:0] table_value;
   } shaper_req_type;

   // One row of the directed table: either a register write or a request,
   // the latter optionally carrying a hand-written response.
   typedef struct packed {
      logic                     cfg;
      logic [CSR_IDX_WIDTH-1:0] csr_sel;
      logic [DATA_WIDTH-1:0]    csr_val;
      shaper_req_type           req;
      logic                     typed;
      shaper_rsp_type           rsp;
   } stim_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [CMD_WIDTH-1:0]     req_command = CMD_ENQUEUE;
   logic [LEN_WIDTH-1:0]     req_packet_length = '0;
   logic [DATA_WIDTH-1:0]    req_now_time = '0;
   logic [TIDX_WIDTH-1:0]    req_table_index = '0;
   logic [DATA_WIDTH-1:0]    req_table_value = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [STATUS_WIDTH-1:0]  rsp_status;
   logic [DATA_WIDTH-1:0]    rsp_wait_time;
   logic [DATA_WIDTH-1:0]    rsp_backlog_bytes;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_IDX_WIDTH-1:0] csr_index = CSR_SIZE_SHIFT;
   logic [DATA_WIDTH-1:0]    csr_wr_data = '0;

   // Shadow registers and shaper state, as they stand after reset.
   logic [SHIFT_WIDTH-1:0]   cfg_shift = SIZE_SHIFT_RESET;
   logic [DATA_WIDTH-1:0]    cfg_depth = '0;
   logic [DATA_WIDTH-1:0]    cfg_limit = '0;
   logic [DATA_WIDTH-1:0]    st_backlog = '0;
   logic [DATA_WIDTH-1:0]    st_tokens = '0;
   logic [DATA_WIDTH-1:0]    st_checkpoint = '0;
   logic [DATA_WIDTH-1:0]    size_time_tbl [0:TBS_TABLE_ENTRIES-1];
   bit                       tbl_written [0:TBS_TABLE_ENTRIES-1];

   shaper_rsp_type           pending_rsp [$];
   bit                       no_idle = 1'b0;
   int                       stall_left = 2;
   int                       quiet_cycles = 0;
   int                       errors = 0;
   int                       requests_sent = 0;
   int                       settings_used = 1;
   int                       status_seen [0:7];
   logic [DATA_WIDTH-1:0]    cur_now = '0;

   token_bucket_shaper i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_packet_length (req_packet_length),
      .req_now_time      (req_now_time),
      .req_table_index   (req_table_index),
      .req_table_value   (req_table_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_wait_time     (rsp_wait_time),
      .rsp_backlog_bytes (rsp_backlog_bytes),
      .csr_wr_en         (csr_wr_en),
      .csr_index         (csr_index),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Size class of a packet under the current shift, saturated at the last entry.
   function automatic logic [TIDX_WIDTH-1:0] size_class(input logic [LEN_WIDTH-1:0] len);
      logic [LEN_WIDTH-1:0] idx;
      idx = len >> cfg_shift;
      if (idx > TBS_TABLE_ENTRIES - 1)
         return TIDX_WIDTH'(TBS_TABLE_ENTRIES - 1);
      return idx[TIDX_WIDTH-1:0];
   endfunction

   // Advance the shadow shaper by one request and return the response it owes.
   function automatic shaper_rsp_type shape_request(input shaper_req_type r);
      shaper_rsp_type        o;
      logic [DATA_WIDTH:0]   sum;
      logic [DATA_WIDTH-1:0] elapsed;
      longint                credit;
      longint                deficit;
      o.status    = ST_DONE;
      o.wait_time = '0;
      case (r.command)
         CMD_ENQUEUE: begin
            // tail drop: compare the unwrapped sum against the limit
            sum = {1'b0, st_backlog} + (DATA_WIDTH + 1)'(r.packet_length);
            if (sum <= {1'b0, cfg_limit}) begin
               st_backlog = sum[DATA_WIDTH-1:0];
               o.status   = ST_ACCEPTED;
            end else begin
               o.status = ST_DROPPED;
            end
         end
         CMD_DEQUEUE: begin
            elapsed = r.now_time - st_checkpoint;
            if (elapsed > cfg_depth)
               elapsed = cfg_depth;
            credit = longint'({32'd0, elapsed}) + longint'({32'd0, st_tokens})
                   - longint'({32'd0, size_time_tbl[size_class(r.packet_length)]});
            if (credit >= 0) begin
               st_checkpoint = r.now_time;
               st_tokens = (credit > longint'({32'd0, cfg_depth})) ? cfg_depth
                                                                   : credit[DATA_WIDTH-1:0];
               st_backlog = (st_backlog >= r.packet_length) ? st_backlog - r.packet_length
                                                            : '0;
               o.status = ST_SENT;
            end else begin
               deficit     = -credit;
               o.wait_time = deficit[DATA_WIDTH-1:0];
               o.status    = ST_THROTTLED;
            end
         end
         CMD_RESET: begin
            st_backlog    = '0;
            st_checkpoint = r.now_time;
            st_tokens     = cfg_depth;
         end
         default: begin
            size_time_tbl[r.table_index] = r.table_value;
            tbl_written[r.table_index]   = 1'b1;
         end
      endcase
      o.backlog_bytes = st_backlog;
      return o;
   endfunction

   function automatic shaper_req_type make_req(input logic [CMD_WIDTH-1:0] cmd,
                                               input logic [LEN_WIDTH-1:0] len,
                                               input logic [DATA_WIDTH-1:0] now,
                                               input logic [TIDX_WIDTH-1:0] tidx,
                                               input logic [DATA_WIDTH-1:0] tval);
      shaper_req_type r;
      r.command       = cmd;
      r.packet_length = len;
      r.now_time      = now;
      r.table_index   = tidx;
      r.table_value   = tval;
      return r;
   endfunction

   // Row checked against the predictor.
   function automatic stim_row_type req_row(input logic [CMD_WIDTH-1:0] cmd,
                                            input logic [LEN_WIDTH-1:0] len,
                                            input logic [DATA_WIDTH-1:0] now,
                                            input logic [TIDX_WIDTH-1:0] tidx,
                                            input logic [DATA_WIDTH-1:0] tval);
      stim_row_type row;
      row       = '0;
      row.req   = make_req(cmd, len, now, tidx, tval);
      return row;
   endfunction

   // Row with the response written out by hand.
   function automatic stim_row_type chk_row(input logic [CMD_WIDTH-1:0] cmd,
                                            input logic [LEN_WIDTH-1:0] len,
                                            input logic [DATA_WIDTH-1:0] now,
                                            input logic [TIDX_WIDTH-1:0] tidx,
                                            input logic [DATA_WIDTH-1:0] tval,
                                            input logic [STATUS_WIDTH-1:0] status,
                                            input logic [DATA_WIDTH-1:0] wait_t,
                                            input logic [DATA_WIDTH-1:0] backlog);
      stim_row_type row;
      row                   = '0;
      row.req               = make_req(cmd, len, now, tidx, tval);
      row.typed             = 1'b1;
      row.rsp.status        = status;
      row.rsp.wait_time     = wait_t;
      row.rsp.backlog_bytes = backlog;
      return row;
   endfunction

   function automatic stim_row_type cfg_row(input logic [CSR_IDX_WIDTH-1:0] sel,
                                            input logic [DATA_WIDTH-1:0] val);
      stim_row_type row;
      row         = '0;
      row.cfg     = 1'b1;
      row.csr_sel = sel;
      row.csr_val = val;
      return row;
   endfunction

   function automatic logic [LEN_WIDTH-1:0] draw_length();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         2, 3, 4: return LEN_WIDTH'($urandom_range(0, 65535));
         default: return LEN_WIDTH'($urandom_range(0, 1500));
      endcase
   endfunction

   function automatic logic [DATA_WIDTH-1:0] draw_cost();
      case ($urandom_range(0, 9))
         0:       return $urandom;
         1:       return $urandom_range(0, 50);
         default: return $urandom_range(0, 4000);
      endcase
   endfunction

   // Pick a dequeue length whose size class has a loaded entry; entry 0 is
   // always loaded by the directed part, so length zero is the fallback.
   function automatic logic [LEN_WIDTH-1:0] readable_length();
      logic [LEN_WIDTH-1:0] len;
      for (int t = 0; t < 32; t++) begin
         len = draw_length();
         if (tbl_written[size_class(len)])
            return len;
      end
      return '0;
   endfunction

   function automatic shaper_req_type random_request(input int table_pct);
      shaper_req_type r;
      int unsigned    roll;
      roll = $urandom_range(0, 99);
      // mostly let time creep forward; now and then jump anywhere, wrap included
      if ($urandom_range(0, 19) == 0)
         cur_now = $urandom;
      else
         cur_now = cur_now + $urandom_range(0, 3000);
      r.now_time      = cur_now;
      r.table_index   = TIDX_WIDTH'($urandom_range(0, TBS_TABLE_ENTRIES - 1));
      r.table_value   = draw_cost();
      r.packet_length = draw_length();
      if (roll < table_pct) begin
         r.command = CMD_TABLE;
      end else if (roll < table_pct + 5) begin
         r.command = CMD_RESET;
      end else if (roll < table_pct + 50) begin
         r.command = CMD_ENQUEUE;
      end else begin
         r.command       = CMD_DEQUEUE;
         r.packet_length = readable_length();
      end
      return r;
   endfunction

   // Present one request after a random gap unless no_idle is set, hold it until
   // accepted, then queue the response it owes. Entered and left at a falling edge.
   task automatic issue(input shaper_req_type r, input logic typed,
                        input shaper_rsp_type given);
      int             gap;
      shaper_rsp_type predicted;
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= r.command;
      req_packet_length <= r.packet_length;
      req_now_time      <= r.now_time;
      req_table_index   <= r.table_index;
      req_table_value   <= r.table_value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predicted = shape_request(r);
      pending_rsp.push_back(typed ? given : predicted);
      requests_sent++;
      @(negedge clock);
   endtask

   // Hold off the sender until every outstanding response has come back.
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   // Write one register while the shaper is idle and mirror it in the shadow copy.
   task automatic write_csr(input logic [CSR_IDX_WIDTH-1:0] sel,
                            input logic [DATA_WIDTH-1:0] val);
      csr_wr_en   <= 1'b1;
      csr_index   <= sel;
      csr_wr_data <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      case (sel)
         CSR_SIZE_SHIFT:    cfg_shift = val[SHIFT_WIDTH-1:0];
         CSR_BUCKET_DEPTH:  cfg_depth = val;
         CSR_BACKLOG_LIMIT: cfg_limit = val;
         default: ;
      endcase
      @(negedge clock);
   endtask

   // Response side: check every accepted response against the oldest
   // expectation, then draw how long to stall before taking the next one.
   always @(posedge clock) begin : check_rsp
      shaper_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: response with nothing pending: status %0d wait %0d backlog %0d",
                     $time, rsp_status, rsp_wait_time, rsp_backlog_bytes);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_status !== want.status) begin
               $display("%0t: status mismatch: expected %0d, got %0d",
                        $time, want.status, rsp_status);
               errors++;
            end
            if (rsp_wait_time !== want.wait_time) begin
               $display("%0t: wait_time mismatch: expected %0d, got %0d",
                        $time, want.wait_time, rsp_wait_time);
               errors++;
            end
            if (rsp_backlog_bytes !== want.backlog_bytes) begin
               $display("%0t: backlog_bytes mismatch: expected %0d, got %0d",
                        $time, want.backlog_bytes, rsp_backlog_bytes);
               errors++;
            end
            if (rsp_status < 8)
               status_seen[rsp_status]++;
         end
         stall_left = no_idle ? 0 : $urandom_range(0, 5);
      end
   end

   // Raise stall until the drawn stall count runs out, then release it.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Watchdog: end the run once no handshake has happened for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("%0t: timeout, no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   initial begin : stimulus
      stim_row_type             directed [$];
      logic [SHIFT_WIDTH-1:0]   p_shift;
      logic [DATA_WIDTH-1:0]    p_depth;
      logic [DATA_WIDTH-1:0]    p_limit;
      int                       directed_count;

      foreach (status_seen[i]) status_seen[i] = 0;
      foreach (tbl_written[i]) tbl_written[i] = 1'b0;
      foreach (size_time_tbl[i]) size_time_tbl[i] = '0;

      // Reset values: shift 3, depth 0, limit 0, empty bucket and backlog.
      // A zero-length enqueue fits a zero limit; a full-size one is dropped.
      directed.push_back(chk_row(CMD_ENQUEUE, 16'd0, 32'd0, 8'd0, 32'd0,
                                 ST_ACCEPTED, 32'd0, 32'd0));
      directed.push_back(chk_row(CMD_ENQUEUE, 16'hFFFF, 32'd0, 8'd0, 32'd0,
                                 ST_DROPPED, 32'd0, 32'd0));
      directed.push_back(chk_row(CMD_RESET, 16'hFFFF, 32'd0, 8'hFF, 32'hFFFF_FFFF,
                                 ST_DONE, 32'd0, 32'd0));
      directed.push_back(chk_row(CMD_TABLE, 16'd0, 32'd0, 8'd0, 32'd0,
                                 ST_DONE, 32'd0, 32'd0));
      // zero cost against an empty bucket still sends
      directed.push_back(chk_row(CMD_DEQUEUE, 16'd0, 32'd0, 8'd0, 32'd0,
                                 ST_SENT, 32'd0, 32'd0));
      directed.push_back(chk_row(CMD_TABLE, 16'd0, 32'd0, 8'hFF, 32'd5,
                                 ST_DONE, 32'd0, 32'd0));
      // saturated size class, elapsed time capped by a zero depth
      directed.push_back(chk_row(CMD_DEQUEUE, 16'hFFFF, 32'd100, 8'd0, 32'd0,
                                 ST_THROTTLED, 32'd5, 32'd0));
      directed.push_back(cfg_row(CSR_SIZE_SHIFT, 32'd0));
      directed.push_back(cfg_row(CSR_BUCKET_DEPTH, 32'hFFFF_FFFF));
      directed.push_back(cfg_row(CSR_BACKLOG_LIMIT, 32'hFFFF_FFFF));
      directed.push_back(chk_row(CMD_TABLE, 16'd0, 32'd0, 8'hAA, 32'hFFFF_FFFF,
                                 ST_DONE, 32'd0, 32'd0));
      directed.push_back(chk_row(CMD_TABLE, 16'd0, 32'd0, 8'h55, 32'h1234_5678,
                                 ST_DONE, 32'd0, 32'd0));
      directed.push_back(chk_row(CMD_ENQUEUE, 16'hFFFF, 32'd0, 8'd0, 32'd0,
                                 ST_ACCEPTED, 32'd0, 32'd65535));
      directed.push_back(chk_row(CMD_ENQUEUE, 16'hFFFF, 32'd0, 8'd0, 32'd0,
                                 ST_ACCEPTED, 32'd0, 32'd131070));
      // full-range elapsed time exactly pays for the largest cost
      directed.push_back(req_row(CMD_DEQUEUE, 16'h00AA, 32'hFFFF_FFFF, 8'd0, 32'd0));
      // elapsed time wraps past zero
      directed.push_back(req_row(CMD_DEQUEUE, 16'h0055, 32'h0000_0010, 8'd0, 32'd0));
      directed.push_back(req_row(CMD_RESET, 16'd0, 32'h8000_0000, 8'd0, 32'd0));
      // full bucket sends and the empty backlog saturates at zero
      directed.push_back(req_row(CMD_DEQUEUE, 16'h0055, 32'h8000_0000, 8'd0, 32'd0));
      directed.push_back(req_row(CMD_ENQUEUE, 16'h00FF, 32'h8000_0001, 8'd0, 32'd0));
      directed.push_back(cfg_row(CSR_SIZE_SHIFT, 32'd15));
      directed.push_back(req_row(CMD_TABLE, 16'd0, 32'h8000_0002, 8'd1, 32'd7));
      // send larger than the backlog
      directed.push_back(req_row(CMD_DEQUEUE, 16'hFFFF, 32'h8000_0003, 8'd0, 32'd0));
      directed.push_back(cfg_row(CSR_BACKLOG_LIMIT, 32'd0));
      directed.push_back(req_row(CMD_ENQUEUE, 16'd1, 32'h8000_0004, 8'd0, 32'd0));

      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Walk the directed table; drain before each register write.
      foreach (directed[i]) begin
         if (directed[i].cfg) begin
            drain_responses();
            write_csr(directed[i].csr_sel, directed[i].csr_val);
         end else begin
            issue(directed[i].req, directed[i].typed, directed[i].rsp);
         end
      end
      directed_count = requests_sent;
      cur_now        = 32'h8000_0004;

      // Random phases, each under its own register setting. The drain at the
      // head of every phase holds the sender until all responses are back.
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         drain_responses();
         case (ph)
            0: begin p_shift = 4'd3;  p_depth = 32'd1000;      p_limit = '1;          end
            1: begin p_shift = 4'd0;  p_depth = 32'd0;         p_limit = '0;          end
            2: begin p_shift = 4'd15; p_depth = '1;            p_limit = 32'd100000;  end
            3: begin p_shift = 4'd6;  p_depth = 32'd20000;     p_limit = '1;          end
            5: begin p_shift = 4'd10; p_depth = 32'd5000;      p_limit = 32'd30000;   end
            default: begin
               p_shift = SHIFT_WIDTH'($urandom_range(0, 15));
               p_depth = ($urandom_range(0, 1) == 0) ? $urandom : $urandom_range(0, 200000);
               p_limit = $urandom;
            end
         endcase
         write_csr(CSR_SIZE_SHIFT, {28'd0, p_shift});
         write_csr(CSR_BUCKET_DEPTH, p_depth);
         write_csr(CSR_BACKLOG_LIMIT, p_limit);
         settings_used++;
         // phases 1 and 5 run with no idling on either side
         no_idle = (ph == 1 || ph == 5);
         for (int n = 0; n < PHASE_REQUESTS; n++)
            issue(random_request(ph == 0 ? 30 : 10), 1'b0, '0);
      end

      drain_responses();
      no_idle = 1'b0;
      // let any stray response surface before the verdict
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d requests (%0d directed) under %0d register settings",
               requests_sent, directed_count, settings_used);
      $display("Responses: %0d accepted, %0d dropped, %0d sent, %0d throttled, %0d done",
               status_seen[ST_ACCEPTED], status_seen[ST_DROPPED], status_seen[ST_SENT],
               status_seen[ST_THROTTLED], status_seen[ST_DONE]);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d errors, %0d responses missing", errors, pending_rsp.size());
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

// ===== token_bucket_shaper.f =====
rtl/tbs_pkg.sv
rtl/tbs_ram.sv
rtl/tbs_index.sv
rtl/tbs_decide.sv
rtl/token_bucket_shaper.sv
rtl/tbs_checker.sv
tb/tb.sv
